@@ hw/rtl/qks_pkg.sv @@
package qks_pkg;

  // Field widths fixed by the stream format
  localparam int POS_W       = 16;
  localparam int ID_W        = 16;
  localparam int SIZE_W      = 13;
  localparam int FRAC_BITS   = 4;
  localparam int NUM_SLOTS   = 5;
  localparam int SLOT_IDX_W  = 3;
  localparam int MASK_W      = NUM_SLOTS;

  // Centre in fixed point: (size >> 1) << FRAC_BITS
  localparam int CTR_W  = SIZE_W - 1 + FRAC_BITS;
  // Offset magnitude never exceeds the larger of position and centre
  localparam int OFS_W  = (POS_W > CTR_W) ? POS_W : CTR_W;
  localparam int DIFF_W = OFS_W + 1;
  localparam int PROD_W = 2 * OFS_W;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [SIZE_W-1:0]    WIDTH_RESET      = 13'd640;
  localparam logic [SIZE_W-1:0]    HEIGHT_RESET     = 13'd480;

  // Slot numbering
  localparam logic [SLOT_IDX_W-1:0] SLOT_CENTRE     = 3'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_RIGHT_DOWN = 3'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_RIGHT_UP   = 3'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_LEFT_DOWN  = 3'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_LEFT_UP    = 3'd4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_LAST       = 3'd4;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_DROP  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [ID_W-1:0]       id;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic                  has_point;
    logic [SLOT_IDX_W-1:0] slot_index;
  } item_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] quad;
    logic [OFS_W-1:0]      cheb;
    logic [PROD_W-1:0]     prod;
  } score_t;

  typedef struct packed {
    logic [MASK_W-1:0] taken_mask;
    logic              slot_valid;
    logic [ID_W-1:0]   slot_feature;
    logic [POS_W-1:0]  slot_x;
    logic [POS_W-1:0]  slot_y;
  } result_t;

  // Chebyshev distance, offset product and quadrant slot of a point
  function automatic score_t score_of(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy);
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] ndx;
    logic [DIFF_W-1:0] ndy;
    logic [OFS_W-1:0]  ax;
    logic [OFS_W-1:0]  ay;
    score_t            s;
    dx  = DIFF_W'(x) - DIFF_W'(cx);
    dy  = DIFF_W'(y) - DIFF_W'(cy);
    ndx = DIFF_W'(0) - dx;
    ndy = DIFF_W'(0) - dy;
    ax  = dx[DIFF_W-1] ? ndx[OFS_W-1:0] : dx[OFS_W-1:0];
    ay  = dy[DIFF_W-1] ? ndy[OFS_W-1:0] : dy[OFS_W-1:0];
    s.cheb = (ax > ay) ? ax : ay;
    s.prod = PROD_W'(ax) * PROD_W'(ay);
    if (!dx[DIFF_W-1]) begin
      s.quad = dy[DIFF_W-1] ? SLOT_RIGHT_UP : SLOT_RIGHT_DOWN;
    end else begin
      s.quad = dy[DIFF_W-1] ? SLOT_LEFT_UP : SLOT_LEFT_DOWN;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/qks_score_stage.sv @@
// Input register, then candidate scoring into the second stage register
module qks_score_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  qks_pkg::item_t            item_i,
  input  logic [qks_pkg::CTR_W-1:0] ctr_x_i,
  input  logic [qks_pkg::CTR_W-1:0] ctr_y_i,
  output logic                      valid_o,
  output qks_pkg::item_t            item_o,
  output qks_pkg::score_t           score_o
);

  logic            in_valid_q;
  qks_pkg::item_t  in_item_q;
  logic            sc_valid_q;
  qks_pkg::item_t  sc_item_q;
  qks_pkg::score_t sc_score_q;
  qks_pkg::score_t score_d;

  assign score_d = qks_pkg::score_of(in_item_q.x, in_item_q.y, ctr_x_i, ctr_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sc_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept_i;
      sc_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      in_item_q <= item_i;
    end
    if (in_valid_q) begin
      sc_item_q  <= in_item_q;
      sc_score_q <= score_d;
    end
  end

  assign valid_o = sc_valid_q;
  assign item_o  = sc_item_q;
  assign score_o = sc_score_q;

endmodule

@@ hw/rtl/qks_slot_bank.sv @@
// Five key-point slots with cached scores; rescored after a centre change
module qks_slot_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  qks_pkg::item_t            item_i,
  input  qks_pkg::score_t           score_i,
  input  logic                      rescore_start_i,
  input  logic [qks_pkg::CTR_W-1:0] ctr_x_i,
  input  logic [qks_pkg::CTR_W-1:0] ctr_y_i,
  output logic                      rescore_busy_o,
  output logic                      res_valid_o,
  output qks_pkg::result_t          res_o
);

  logic [qks_pkg::NUM_SLOTS-1:0]  valid_q;
  logic [qks_pkg::NUM_SLOTS-1:0]  valid_d;
  logic [qks_pkg::ID_W-1:0]       id_q    [qks_pkg::NUM_SLOTS];
  logic [qks_pkg::POS_W-1:0]      x_q     [qks_pkg::NUM_SLOTS];
  logic [qks_pkg::POS_W-1:0]      y_q     [qks_pkg::NUM_SLOTS];
  logic [qks_pkg::PROD_W-1:0]     score_q [qks_pkg::NUM_SLOTS];
  logic                           rs_busy_q;
  logic [qks_pkg::SLOT_IDX_W-1:0] rs_idx_q;

  logic [qks_pkg::NUM_SLOTS-1:0]  id_eq;
  logic [qks_pkg::NUM_SLOTS-1:0]  take;
  logic                           is_offer;
  logic                           rd_hit;
  qks_pkg::score_t                rs_score;
  logic [qks_pkg::PROD_W-1:0]     rs_val;
  qks_pkg::result_t               res;

  // Rescore one slot per cycle against the new centre
  assign rs_score = qks_pkg::score_of(x_q[rs_idx_q], y_q[rs_idx_q], ctr_x_i, ctr_y_i);
  assign rs_val   = (rs_idx_q == qks_pkg::SLOT_CENTRE) ?
                    qks_pkg::PROD_W'(rs_score.cheb) : rs_score.prod;

  always_comb begin
    is_offer = item_valid_i && (item_i.op == qks_pkg::OP_OFFER) && item_i.has_point;
    for (int s = 0; s < qks_pkg::NUM_SLOTS; s++) begin
      id_eq[s] = (id_q[s] == item_i.id);
    end
    take[0] = is_offer &&
              (!valid_q[0] || (qks_pkg::PROD_W'(score_i.cheb) < score_q[0]));
    for (int s = 1; s < qks_pkg::NUM_SLOTS; s++) begin
      take[s] = is_offer && (score_i.quad == qks_pkg::SLOT_IDX_W'(s)) &&
                (!valid_q[s] || (score_i.prod > score_q[s]));
    end

    rd_hit = (item_i.slot_index <= qks_pkg::SLOT_LAST) && valid_q[item_i.slot_index];

    valid_d          = valid_q;
    res.taken_mask   = '0;
    res.slot_valid   = 1'b0;
    res.slot_feature = '0;
    res.slot_x       = '0;
    res.slot_y       = '0;
    case (item_i.op)
      qks_pkg::OP_OFFER: begin
        valid_d        = valid_q | take;
        res.taken_mask = take | (valid_q & id_eq);
      end
      qks_pkg::OP_DROP: begin
        valid_d = valid_q & ~id_eq;
      end
      qks_pkg::OP_READ: begin
        res.taken_mask = valid_q & id_eq;
        if (rd_hit) begin
          res.slot_valid   = 1'b1;
          res.slot_feature = id_q[item_i.slot_index];
          res.slot_x       = x_q[item_i.slot_index];
          res.slot_y       = y_q[item_i.slot_index];
        end
      end
      qks_pkg::OP_CLEAR: begin
        valid_d = '0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rs_busy_q <= 1'b0;
      rs_idx_q  <= qks_pkg::SLOT_CENTRE;
    end else begin
      if (item_valid_i) begin
        valid_q <= valid_d;
      end
      if (rescore_start_i) begin
        rs_busy_q <= 1'b1;
        rs_idx_q  <= qks_pkg::SLOT_CENTRE;
      end else if (rs_busy_q) begin
        if (rs_idx_q == qks_pkg::SLOT_LAST) begin
          rs_busy_q <= 1'b0;
        end
        rs_idx_q <= rs_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < qks_pkg::NUM_SLOTS; s++) begin
      if (take[s]) begin
        id_q[s]    <= item_i.id;
        x_q[s]     <= item_i.x;
        y_q[s]     <= item_i.y;
        score_q[s] <= (s == 0) ? qks_pkg::PROD_W'(score_i.cheb) : score_i.prod;
      end else if (rs_busy_q && (rs_idx_q == qks_pkg::SLOT_IDX_W'(s))) begin
        score_q[s] <= rs_val;
      end
    end
  end

  assign rescore_busy_o = rs_busy_q;
  assign res_valid_o    = item_valid_i;
  assign res_o          = res;

endmodule

@@ hw/rtl/qks_out_queue.sv @@
// Small result queue between the slot bank and the output stream
module qks_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  qks_pkg::result_t wr_data_i,
  input  logic             rd_i,
  output logic             rd_valid_o,
  output qks_pkg::result_t rd_data_o
);

  qks_pkg::result_t                entry_q [qks_pkg::OQ_DEPTH];
  logic [qks_pkg::OQ_PTR_W-1:0]    wr_ptr_q;
  logic [qks_pkg::OQ_PTR_W-1:0]    rd_ptr_q;
  logic [qks_pkg::OQ_CNT_W-1:0]    cnt_q;
  logic                            pop;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign pop        = rd_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i && pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hw/rtl/quadrant_keypoint_selector.sv @@
// Quadrant key-point selector.
// Slave stream carries one operation per item (offer, drop id, read slot,
// clear); tuser holds the operation code. Master stream returns exactly one
// result item per input item, in order: the mask of slots now holding the
// item's id, plus the slot contents for a read.
// m_axis_tvalid rises after an item passes the input register, the scoring
// stage with the offset multiplier and the slot update into a 4-entry
// result queue. Throughput: one item per cycle while s_axis_tready is high;
// the slot state is read and written in a single stage so consecutive items
// see each other's updates.
// s_axis_tready drops when 4 items are accepted but not yet delivered, so a
// stalled receiver backs up the input after the queue fills; nothing is lost.
// Image sizes are written through cfg_*; each write starts a rescore of the
// cached slot scores against the new centre, one slot at a time; s_axis_tready
// is low during the write and the rescore.
// Reset: all slots empty, sizes 640 x 480, queue empty.
module quadrant_keypoint_selector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] feature_id, [31:16] pos_x, [47:32] pos_y, [48] has_point,
  // [51:49] slot_index, [55:52] zero
  input  logic [55:0]                   s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                    s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [4:0] taken_mask, [20:5] slot_feature, [36:21] slot_x, [52:37] slot_y,
  // [55:53] zero
  output logic [55:0]                   m_axis_tdata,
  // [0] slot_valid
  output logic [0:0]                    m_axis_tuser,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [qks_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [qks_pkg::SIZE_W-1:0]    cfg_data_i
);

  logic [qks_pkg::SIZE_W-1:0]   width_q;
  logic [qks_pkg::SIZE_W-1:0]   height_q;
  logic [qks_pkg::CTR_W-1:0]    ctr_x;
  logic [qks_pkg::CTR_W-1:0]    ctr_y;
  logic [qks_pkg::OQ_CNT_W-1:0] credit_q;   // items accepted, not yet delivered
  logic                         in_acc;
  logic                         out_acc;
  logic                         rescore_busy;
  qks_pkg::item_t               in_item;
  logic                         sc_valid;
  qks_pkg::item_t               sc_item;
  qks_pkg::score_t              sc_score;
  logic                         res_valid;
  qks_pkg::result_t             res;
  qks_pkg::result_t             out_res;

  // Centre in fixed point: whole-pixel half size, fraction bits zero
  assign ctr_x = {width_q[qks_pkg::SIZE_W-1:1], qks_pkg::FRAC_BITS'(0)};
  assign ctr_y = {height_q[qks_pkg::SIZE_W-1:1], qks_pkg::FRAC_BITS'(0)};

  // Unpack the input item
  assign in_item.op         = qks_pkg::op_e'(s_axis_tuser);
  assign in_item.id         = s_axis_tdata[15:0];
  assign in_item.x          = s_axis_tdata[31:16];
  assign in_item.y          = s_axis_tdata[47:32];
  assign in_item.has_point  = s_axis_tdata[48];
  assign in_item.slot_index = s_axis_tdata[51:49];

  // Credit limit keeps the result queue from overflowing
  assign s_axis_tready = (credit_q < qks_pkg::OQ_CNT_W'(qks_pkg::OQ_DEPTH)) &&
                         !rescore_busy && !cfg_we_i;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= qks_pkg::WIDTH_RESET;
      height_q <= qks_pkg::HEIGHT_RESET;
      credit_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          qks_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          qks_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: width_q <= width_q;
        endcase
      end
      if (in_acc && !out_acc) begin
        credit_q <= credit_q + 1'b1;
      end else if (!in_acc && out_acc) begin
        credit_q <= credit_q - 1'b1;
      end
    end
  end

  qks_score_stage u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .item_i   (in_item),
    .ctr_x_i  (ctr_x),
    .ctr_y_i  (ctr_y),
    .valid_o  (sc_valid),
    .item_o   (sc_item),
    .score_o  (sc_score)
  );

  qks_slot_bank u_slots (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (sc_valid),
    .item_i          (sc_item),
    .score_i         (sc_score),
    .rescore_start_i (cfg_we_i),
    .ctr_x_i         (ctr_x),
    .ctr_y_i         (ctr_y),
    .rescore_busy_o  (rescore_busy),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  qks_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (res_valid),
    .wr_data_i  (res),
    .rd_i       (m_axis_tready),
    .rd_valid_o (m_axis_tvalid),
    .rd_data_o  (out_res)
  );

  // Pack the result item
  assign m_axis_tdata = {3'b000, out_res.slot_y, out_res.slot_x,
                         out_res.slot_feature, out_res.taken_mask};
  assign m_axis_tuser = out_res.slot_valid;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import qks_pkg::*;

  // Run shape
  localparam int PLAN_LEN      = 24;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 322;
  localparam int IDLE_PCT      = 28;
  localparam int STALL_LIMIT   = 2000;
  // 3-stage pipeline plus the rescore that follows a size write
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 8;

  // Centre of the default 640 x 480 image in 12.4 fixed point
  localparam logic [POS_W-1:0] CX_RST = 16'h1400;
  localparam logic [POS_W-1:0] CY_RST = 16'h0F00;
  // Slot selects beyond the last slot
  localparam logic [SLOT_IDX_W-1:0] SLOT_PAST = 3'd5;
  localparam logic [SLOT_IDX_W-1:0] SLOT_TOP  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_IMAGE_WIDTH;
  logic [SIZE_W-1:0]    cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  quadrant_keypoint_selector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Slot tracker: own copy of the sizes and the five slots
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] width_q  = WIDTH_RESET;
  logic [SIZE_W-1:0] height_q = HEIGHT_RESET;
  logic              held_ok  [NUM_SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0]   held_tag [NUM_SLOTS] = '{default: '0};
  logic [POS_W-1:0]  held_col [NUM_SLOTS] = '{default: '0};
  logic [POS_W-1:0]  held_row [NUM_SLOTS] = '{default: '0};

  // Directed rows either carry a typed-in mask or defer to the tracker
  typedef struct packed {
    logic              known;
    logic [MASK_W-1:0] mask;
  } typed_mask_t;

  result_t     pending_results [$];
  typed_mask_t typed_masks [$];

  int  errors      = 0;
  int  items_in    = 0;
  int  read_hits   = 0;
  int  masks_set   = 0;
  int  quiet_cycles = 0;
  bit  steady      = 1'b0;  // no idling on either side while set

  function automatic longint centre_of(logic [SIZE_W-1:0] size);
    return longint'(size >> 1) << FRAC_BITS;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint larger(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Applies one operation to the tracked slots and returns its result
  function automatic result_t update_slots(item_t it);
    result_t r;
    longint  cx, cy, dx, dy, ax, ay, hx, hy;
    int      q;
    bit      take_c, take_q;
    r  = '0;
    cx = centre_of(width_q);
    cy = centre_of(height_q);
    case (it.op)
      OP_OFFER: begin
        if (it.has_point) begin
          dx = longint'(it.x) - cx;
          dy = longint'(it.y) - cy;
          ax = magnitude(dx);
          ay = magnitude(dy);
          if (dx >= 0) q = (dy >= 0) ? int'(SLOT_RIGHT_DOWN) : int'(SLOT_RIGHT_UP);
          else         q = (dy >= 0) ? int'(SLOT_LEFT_DOWN)  : int'(SLOT_LEFT_UP);
          // both scores are taken from held coordinates against today's centre
          hx = magnitude(longint'(held_col[SLOT_CENTRE]) - cx);
          hy = magnitude(longint'(held_row[SLOT_CENTRE]) - cy);
          take_c = !held_ok[SLOT_CENTRE] || (larger(ax, ay) < larger(hx, hy));
          hx = magnitude(longint'(held_col[q]) - cx);
          hy = magnitude(longint'(held_row[q]) - cy);
          take_q = !held_ok[q] || (ax * ay > hx * hy);
          if (take_c) begin
            held_ok[SLOT_CENTRE]  = 1'b1;
            held_tag[SLOT_CENTRE] = it.id;
            held_col[SLOT_CENTRE] = it.x;
            held_row[SLOT_CENTRE] = it.y;
          end
          if (take_q) begin
            held_ok[q]  = 1'b1;
            held_tag[q] = it.id;
            held_col[q] = it.x;
            held_row[q] = it.y;
          end
        end
      end
      OP_DROP: begin
        for (int s = 0; s < NUM_SLOTS; s++)
          if (held_ok[s] && held_tag[s] == it.id) held_ok[s] = 1'b0;
      end
      OP_READ: begin
        if (it.slot_index <= SLOT_LAST && held_ok[it.slot_index]) begin
          r.slot_valid   = 1'b1;
          r.slot_feature = held_tag[it.slot_index];
          r.slot_x       = held_col[it.slot_index];
          r.slot_y       = held_row[it.slot_index];
        end
      end
      default: begin
        for (int s = 0; s < NUM_SLOTS; s++) held_ok[s] = 1'b0;
      end
    endcase
    for (int s = 0; s < NUM_SLOTS; s++)
      if (held_ok[s] && held_tag[s] == it.id) r.taken_mask[s] = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side: size writes and accepted items feed the tracker
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : track_inputs
    item_t       it;
    result_t     r;
    typed_mask_t tm;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_IMAGE_WIDTH) width_q = cfg_data_i;
      else                              height_q = cfg_data_i;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it.op         = op_e'(s_axis_tuser);
      it.id         = s_axis_tdata[15:0];
      it.x          = s_axis_tdata[31:16];
      it.y          = s_axis_tdata[47:32];
      it.has_point  = s_axis_tdata[48];
      it.slot_index = s_axis_tdata[51:49];
      r  = update_slots(it);
      tm = typed_masks.pop_front();
      // typed rows: slot fields are zero, mask as written in the plan
      if (tm.known) r = '{taken_mask: tm.mask, default: '0};
      pending_results = {pending_results, r};
      items_in++;
      if (r.slot_valid) read_hits++;
      if (r.taken_mask != '0) masks_set++;
    end
  end

  // ---------------------------------------------------------------------
  // Output side: every result item against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic flag_field(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_outputs
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: expected none, got tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        flag_field("taken_mask",   ID_W'(want.taken_mask), ID_W'(m_axis_tdata[4:0]));
        flag_field("slot_valid",   ID_W'(want.slot_valid), ID_W'(m_axis_tuser[0]));
        flag_field("slot_feature", want.slot_feature,      m_axis_tdata[20:5]);
        flag_field("slot_x",       want.slot_x,            m_axis_tdata[36:21]);
        flag_field("slot_y",       want.slot_y,            m_axis_tdata[52:37]);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Presents one item and returns at the edge where it is taken. tvalid is
  // left high so a back-to-back item needs only one assignment per step.
  task automatic push_item(item_t it, logic known, logic [MASK_W-1:0] mask);
    typed_mask_t tm;
    tm.known    = known;
    tm.mask     = mask;
    typed_masks = {typed_masks, tm};
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(0, 99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it.slot_index, it.has_point, it.y, it.x, it.id};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sizes change only with nothing in flight
  task automatic write_sizes(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // let the rescore triggered by the width write finish first
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly inside the image, sometimes anywhere in the 16-bit range
  function automatic logic [POS_W-1:0] random_pos(logic [SIZE_W-1:0] size);
    int span;
    span = (int'(size) + 1) << FRAC_BITS;
    if (span > 65535) span = 65535;
    if ($urandom_range(0, 99) < 80) return POS_W'($urandom_range(0, span));
    return POS_W'($urandom);
  endfunction

  // Small id pool so drops and masks hit; the rest spans every id bit
  function automatic item_t random_item();
    item_t it;
    int    roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)      it.op = OP_OFFER;
    else if (roll < 80) it.op = OP_READ;
    else if (roll < 96) it.op = OP_DROP;
    else                it.op = OP_CLEAR;
    it.id = ($urandom_range(0, 99) < 70) ? ID_W'($urandom_range(0, 19)) : ID_W'($urandom);
    it.x  = random_pos(width_q);
    it.y  = random_pos(height_q);
    it.has_point  = ($urandom_range(0, 99) < 90);
    it.slot_index = ($urandom_range(0, 99) < 90) ? SLOT_IDX_W'($urandom_range(0, 4))
                                                 : SLOT_IDX_W'($urandom_range(5, 7));
    return it;
  endfunction

  typedef struct packed {
    op_e                   op;
    logic [ID_W-1:0]       id;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic                  has_point;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  known;
    logic [MASK_W-1:0]     mask;
  } plan_row_t;

  // Directed rows at the default 640 x 480 size. Typed masks only where the
  // answer is obvious: empty slots, ignored offers, a first offer into empty slots, drops and clears.
  plan_row_t plan [PLAN_LEN] = '{
    // reads straight after reset, in range and far past the last slot
    '{OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0, SLOT_CENTRE,     1'b1, 5'b00000},
    '{OP_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, SLOT_TOP,        1'b1, 5'b00000},
    // offer without a point is ignored, then the same one with a point
    '{OP_OFFER, 16'h1234, CX_RST,   CY_RST,   1'b0, SLOT_CENTRE,     1'b1, 5'b00000},
    '{OP_OFFER, 16'h1234, CX_RST,   CY_RST,   1'b1, SLOT_CENTRE,     1'b1, 5'b00011},
    // corners: one per quadrant, coordinate extremes
    '{OP_OFFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, SLOT_RIGHT_DOWN, 1'b0, 5'b00000},
    '{OP_OFFER, 16'h0000, 16'h0000, 16'h0000, 1'b1, SLOT_LEFT_UP,    1'b0, 5'b00000},
    '{OP_OFFER, 16'h0001, 16'hFFFF, 16'h0000, 1'b1, SLOT_RIGHT_UP,   1'b0, 5'b00000},
    '{OP_OFFER, 16'h0002, 16'h0000, 16'hFFFF, 1'b1, SLOT_LEFT_DOWN,  1'b0, 5'b00000},
    // equal product: held feature stays
    '{OP_OFFER, 16'h0003, 16'h0000, 16'h0000, 1'b1, SLOT_CENTRE,     1'b0, 5'b00000},
    // one step off centre loses to the exact centre
    '{OP_OFFER, 16'h0004, CX_RST + 16'd1, CY_RST, 1'b1, SLOT_CENTRE, 1'b0, 5'b00000},
    '{OP_READ,  16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_CENTRE,     1'b0, 5'b00000},
    '{OP_READ,  16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_RIGHT_DOWN, 1'b0, 5'b00000},
    '{OP_READ,  16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_RIGHT_UP,   1'b0, 5'b00000},
    '{OP_READ,  16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_LEFT_DOWN,  1'b0, 5'b00000},
    '{OP_READ,  16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_LEFT_UP,    1'b0, 5'b00000},
    '{OP_READ,  16'hBEEF, 16'h0000, 16'h0000, 1'b0, SLOT_PAST,       1'b1, 5'b00000},
    // drop a held id, then one nobody holds
    '{OP_DROP,  16'hFFFF, 16'h0000, 16'h0000, 1'b0, SLOT_CENTRE,     1'b1, 5'b00000},
    '{OP_DROP,  16'hBEEF, 16'h0000, 16'h0000, 1'b0, SLOT_CENTRE,     1'b1, 5'b00000},
    '{OP_READ,  16'hBEEF, 16'h0000, 16'h0000, 1'b0, SLOT_RIGHT_DOWN, 1'b1, 5'b00000},
    // freed quadrant refills
    '{OP_OFFER, 16'hABCD, CX_RST + 16'd1, CY_RST + 16'd1, 1'b1, SLOT_CENTRE, 1'b0, 5'b00000},
    '{OP_READ,  16'hABCD, 16'h0000, 16'h0000, 1'b0, SLOT_RIGHT_DOWN, 1'b0, 5'b00000},
    '{OP_CLEAR, 16'h1234, 16'h0000, 16'h0000, 1'b0, SLOT_CENTRE,     1'b1, 5'b00000},
    '{OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0, SLOT_LEFT_UP,    1'b1, 5'b00000},
    '{OP_OFFER, 16'h5555, CX_RST,   CY_RST,   1'b1, SLOT_CENTRE,     1'b0, 5'b00000}
  };

  initial begin : stimulus
    item_t             it;
    logic [SIZE_W-1:0] w, h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      it.op         = plan[k].op;
      it.id         = plan[k].id;
      it.x          = plan[k].x;
      it.y          = plan[k].y;
      it.has_point  = plan[k].has_point;
      it.slot_index = plan[k].slot;
      push_item(it, plan[k].known, plan[k].mask);
    end

    // size settings: 1-pixel image, largest legal, the 13-bit extremes,
    // two random ones (the first with no idling at all), back to default
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin w = 13'd1;    h = 13'd1;    end
        1:       begin w = 13'd4096; h = 13'd4096; end
        2:       begin w = 13'd0;    h = 13'h1FFF; end
        5:       begin w = WIDTH_RESET; h = HEIGHT_RESET; end
        default: begin
          w = SIZE_W'($urandom_range(1, 4096));
          h = SIZE_W'($urandom_range(1, 4096));
        end
      endcase
      write_sizes(w, h);
      steady = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) push_item(random_item(), 1'b0, '0);
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items over %0d image sizes plus the default directed rows.",
             items_in, NUM_PHASES);
    $display("%0d reads found a filled slot; %0d results had a non-empty taken mask.",
             read_hits, masks_set);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/qks_pkg.sv
hw/rtl/qks_score_stage.sv
hw/rtl/qks_slot_bank.sv
hw/rtl/qks_out_queue.sv
hw/rtl/quadrant_keypoint_selector.sv
tb/testbench.sv
